[hw/rtl/adc_scan_block_averager_unit_defines.svh]
// Assertion helpers for the checker file of this block.
`ifndef ADC_SCAN_BLOCK_AVERAGER_UNIT_DEFINES_SVH
`define ADC_SCAN_BLOCK_AVERAGER_UNIT_DEFINES_SVH

// Checked on every rising edge outside reset.
`define ADC_SBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ADC_SBA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/adc_sba_pkg.sv]
`default_nettype none

package adc_sba_pkg;

  localparam int CHAN_W   = 3;
  localparam int ROUND_W  = 4;
  localparam int SUM_W    = 16;
  localparam int SAMPLE_W = 12;
  localparam int BYTE_W   = 8;
  localparam int MODE_W   = 8;
  localparam int AVG_W    = 12;
  localparam int SCALED_W = 15;

  localparam int CHANNELS_DEF = 8;
  localparam int ROUNDS_DEF   = 10;

  localparam logic [BYTE_W-1:0] SAMPLE_HI_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] CMD_BASE       = 8'h06;

  localparam logic KIND_CMD = 1'b0;
  localparam logic KIND_AVG = 1'b1;

  localparam int unsigned FULL_SCALE = 4095;
  localparam int unsigned SENSE_OHMS = 493;
  localparam int unsigned MV_FULL    = 10000;
  localparam int unsigned UA_FULL    = 10000000;
  localparam int unsigned MV_DEN     = FULL_SCALE;
  localparam int unsigned UA_DEN     = FULL_SCALE * SENSE_OHMS;

  // Scaling multiplies by a reciprocal held with SC_SHIFT fraction bits, then
  // corrects the quotient by at most one.
  localparam int SC_SHIFT = 16;
  localparam int unsigned MV_RECIP = 32'((64'(MV_FULL) << SC_SHIFT) / MV_DEN);
  localparam int unsigned UA_RECIP = 32'((64'(UA_FULL) << SC_SHIFT) / UA_DEN);
  localparam int SC_RECIP_W = 19;
  localparam int SC_NUM_W   = 24;
  localparam int SC_DEN_W   = 21;

  typedef struct packed {
    logic capture;
    logic accumulate;
    logic load;
    logic mul_av;
    logic fix_av;
    logic mul_sc;
    logic emit_avg;
    logic emit_cmd;
  } ctrl_cmd_t;

  typedef struct packed {
    logic block_done;
    logic idx_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/adc_sba_in_if.sv]
`default_nettype none

interface adc_sba_in_if;
  logic                             valid;
  logic                             ready;
  logic [adc_sba_pkg::BYTE_W-1:0]   rx_byte_mid;
  logic [adc_sba_pkg::BYTE_W-1:0]   rx_byte_low;

  modport source (output valid, output rx_byte_mid, output rx_byte_low, input ready);
  modport sink   (input valid, input rx_byte_mid, input rx_byte_low, output ready);
endinterface

`default_nettype wire

[hw/rtl/adc_sba_out_if.sv]
`default_nettype none

interface adc_sba_out_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic [adc_sba_pkg::CHAN_W-1:0]     channel;
  logic [adc_sba_pkg::BYTE_W-1:0]     tx_byte_first;
  logic [adc_sba_pkg::BYTE_W-1:0]     tx_byte_second;
  logic [adc_sba_pkg::AVG_W-1:0]      average;
  logic [adc_sba_pkg::SCALED_W-1:0]   scaled_value;
  logic                               is_last;

  modport source (output valid, output kind, output channel, output tx_byte_first,
                  output tx_byte_second, output average, output scaled_value,
                  output is_last, input ready);
  modport sink   (input valid, input kind, input channel, input tx_byte_first,
                  input tx_byte_second, input average, input scaled_value,
                  input is_last, output ready);
endinterface

`default_nettype wire

[hw/rtl/adc_sba_ctrl.sv]
`default_nettype none

module adc_sba_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  adc_sba_pkg::dp_status_t status,
  output adc_sba_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_ACC    = 8'b0000_0010,
    ST_LOAD   = 8'b0000_0100,
    ST_AV_MUL = 8'b0000_1000,
    ST_AV_FIX = 8'b0001_0000,
    ST_SC_MUL = 8'b0010_0000,
    ST_SC_FIX = 8'b0100_0000,
    ST_CMD    = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.accumulate = 1'b1;
        state_nxt      = status.block_done ? ST_LOAD : ST_CMD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_AV_MUL;
      end
      ST_AV_MUL: begin
        cmd.mul_av = 1'b1;
        state_nxt  = ST_AV_FIX;
      end
      ST_AV_FIX: begin
        cmd.fix_av = 1'b1;
        state_nxt  = ST_SC_MUL;
      end
      ST_SC_MUL: begin
        cmd.mul_sc = 1'b1;
        state_nxt  = ST_SC_FIX;
      end
      ST_SC_FIX: begin
        // The result waits here until the output register can take it.
        if (status.out_free) begin
          cmd.emit_avg = 1'b1;
          state_nxt    = status.idx_last ? ST_CMD : ST_LOAD;
        end
      end
      ST_CMD: begin
        if (status.out_free) begin
          cmd.emit_cmd = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/adc_sba_dp.sv]
`default_nettype none

module adc_sba_dp #(
  parameter int CHANNELS = adc_sba_pkg::CHANNELS_DEF,
  parameter int ROUNDS   = adc_sba_pkg::ROUNDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [adc_sba_pkg::BYTE_W-1:0]   rx_byte_mid,
  input  logic [adc_sba_pkg::BYTE_W-1:0]   rx_byte_low,
  input  logic                             cfg_we,
  input  logic [adc_sba_pkg::MODE_W-1:0]   cfg_wdata,
  input  adc_sba_pkg::ctrl_cmd_t           cmd,
  output adc_sba_pkg::dp_status_t          status,
  adc_sba_out_if.source                    out_if
);

  localparam int CHAN_W   = adc_sba_pkg::CHAN_W;
  localparam int ROUND_W  = adc_sba_pkg::ROUND_W;
  localparam int SUM_W    = adc_sba_pkg::SUM_W;
  localparam int SAMPLE_W = adc_sba_pkg::SAMPLE_W;
  localparam int BYTE_W   = adc_sba_pkg::BYTE_W;
  localparam int MODE_W   = adc_sba_pkg::MODE_W;
  localparam int AVG_W    = adc_sba_pkg::AVG_W;
  localparam int SCALED_W = adc_sba_pkg::SCALED_W;
  localparam int CIW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // The average is the sum times a truncated reciprocal of ROUNDS; the
  // estimate is at most one low, which the remainder check repairs.
  localparam int          AV_SHIFT = 20;
  localparam int          AV_RW    = AV_SHIFT + 1;
  localparam int          AV_PW    = SUM_W + AV_RW;
  localparam int unsigned AV_RECIP = (32'd1 << AV_SHIFT) / ROUNDS;

  localparam int SC_SHIFT = adc_sba_pkg::SC_SHIFT;
  localparam int SPROD_W  = AVG_W + adc_sba_pkg::SC_RECIP_W;
  localparam int SNUM_W   = AVG_W + adc_sba_pkg::SC_NUM_W;

  logic [SUM_W-1:0]    sums_r [CHANNELS];
  logic [CHAN_W-1:0]   cur_r;
  logic [ROUND_W-1:0]  round_r;
  logic [CHAN_W-1:0]   idx_r;
  logic [MODE_W-1:0]   modes_r;
  logic [SAMPLE_W-1:0] sample_r;

  logic [SUM_W-1:0]    sum_sel_r;
  logic                mode_r;
  logic [AV_PW-1:0]    prod_r;
  logic [AVG_W-1:0]    avg_r;
  logic [SPROD_W-1:0]  sprod_r;
  logic [SNUM_W-1:0]   snum_r;

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic                    out_kind_r;
  logic [CHAN_W-1:0]       out_channel_r;
  logic [BYTE_W-1:0]       out_tx1_r;
  logic [BYTE_W-1:0]       out_tx2_r;
  logic [AVG_W-1:0]        out_avg_r;
  logic [SCALED_W-1:0]     out_scaled_r;
  logic                    out_last_r;

  logic                chan_wrap;
  logic                round_wrap;
  logic [BYTE_W-1:0]   mid_masked;
  logic [SUM_W-1:0]    av_q0;
  logic [SUM_W-1:0]    av_rem;
  logic [SUM_W-1:0]    av_q;
  logic [AVG_W-1:0]    avg_nxt;

  logic [adc_sba_pkg::SC_RECIP_W-1:0] sc_recip;
  logic [adc_sba_pkg::SC_NUM_W-1:0]   sc_num;
  logic [adc_sba_pkg::SC_DEN_W-1:0]   sc_den;
  logic [SCALED_W-1:0]                sc_q0;
  logic [SNUM_W-1:0]                  sc_rem;
  logic [SCALED_W-1:0]                scaled;

  assign chan_wrap  = (cur_r == CHAN_W'(CHANNELS - 1));
  assign round_wrap = (round_r == ROUND_W'(ROUNDS - 1));
  assign mid_masked = rx_byte_mid & adc_sba_pkg::SAMPLE_HI_MASK;

  assign status.block_done = chan_wrap && round_wrap;
  assign status.idx_last   = (idx_r == CHAN_W'(CHANNELS - 1));
  assign status.out_free   = !out_valid_r || out_if.ready;

  // Average: quotient estimate, then one compare and subtract.
  assign av_q0   = prod_r[AV_SHIFT +: SUM_W];
  assign av_rem  = sum_sel_r - av_q0 * SUM_W'(ROUNDS);
  assign av_q    = av_q0 + SUM_W'(av_rem >= SUM_W'(ROUNDS));
  assign avg_nxt = (av_q > SUM_W'(adc_sba_pkg::FULL_SCALE)) ?
                   AVG_W'(adc_sba_pkg::FULL_SCALE) : av_q[AVG_W-1:0];

  // Scaled value: same scheme with mode-dependent constants.
  assign sc_recip = mode_r ? adc_sba_pkg::SC_RECIP_W'(adc_sba_pkg::UA_RECIP)
                           : adc_sba_pkg::SC_RECIP_W'(adc_sba_pkg::MV_RECIP);
  assign sc_num   = mode_r ? adc_sba_pkg::SC_NUM_W'(adc_sba_pkg::UA_FULL)
                           : adc_sba_pkg::SC_NUM_W'(adc_sba_pkg::MV_FULL);
  assign sc_den   = mode_r ? adc_sba_pkg::SC_DEN_W'(adc_sba_pkg::UA_DEN)
                           : adc_sba_pkg::SC_DEN_W'(adc_sba_pkg::MV_DEN);
  assign sc_q0    = sprod_r[SC_SHIFT +: SCALED_W];
  assign sc_rem   = snum_r - SNUM_W'(sc_q0) * SNUM_W'(sc_den);
  assign scaled   = sc_q0 + SCALED_W'(sc_rem >= SNUM_W'(sc_den));

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit_avg || cmd.emit_cmd) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      round_r     <= '0;
      idx_r       <= '0;
      modes_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        sums_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        modes_r <= cfg_wdata;
      end
      if (cmd.accumulate) begin
        sums_r[cur_r[CIW-1:0]] <= sums_r[cur_r[CIW-1:0]] + SUM_W'(sample_r);
        cur_r <= chan_wrap ? '0 : cur_r + CHAN_W'(1);
        if (chan_wrap) begin
          round_r <= round_wrap ? '0 : round_r + ROUND_W'(1);
        end
      end
      if (cmd.load) begin
        sums_r[idx_r[CIW-1:0]] <= '0;
      end
      if (cmd.emit_avg) begin
        idx_r <= status.idx_last ? '0 : idx_r + CHAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= {mid_masked[3:0], rx_byte_low};
    end
    if (cmd.load) begin
      sum_sel_r <= sums_r[idx_r[CIW-1:0]];
      mode_r    <= modes_r[idx_r];
    end
    if (cmd.mul_av) begin
      prod_r <= AV_PW'(sum_sel_r) * AV_PW'(AV_RECIP);
    end
    if (cmd.fix_av) begin
      avg_r <= avg_nxt;
    end
    if (cmd.mul_sc) begin
      sprod_r <= SPROD_W'(avg_r) * SPROD_W'(sc_recip);
      snum_r  <= SNUM_W'(avg_r) * SNUM_W'(sc_num);
    end
    if (cmd.emit_avg) begin
      out_kind_r    <= adc_sba_pkg::KIND_AVG;
      out_channel_r <= idx_r;
      out_tx1_r     <= '0;
      out_tx2_r     <= '0;
      out_avg_r     <= avg_r;
      out_scaled_r  <= scaled;
      out_last_r    <= 1'b0;
    end
    if (cmd.emit_cmd) begin
      out_kind_r    <= adc_sba_pkg::KIND_CMD;
      out_channel_r <= cur_r;
      out_tx1_r     <= adc_sba_pkg::CMD_BASE | BYTE_W'(cur_r[2]);
      out_tx2_r     <= {cur_r[1:0], 6'b0};
      out_avg_r     <= '0;
      out_scaled_r  <= '0;
      out_last_r    <= 1'b1;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.kind           = out_kind_r;
  assign out_if.channel        = out_channel_r;
  assign out_if.tx_byte_first  = out_tx1_r;
  assign out_if.tx_byte_second = out_tx2_r;
  assign out_if.average        = out_avg_r;
  assign out_if.scaled_value   = out_scaled_r;
  assign out_if.is_last        = out_last_r;

endmodule

`default_nettype wire

[hw/rtl/adc_scan_block_averager_unit.sv]
// Scan block averager for a multichannel 12-bit SPI converter.
// in_if takes the middle and last byte of each 3-byte converter reply; the
// sample goes to the accumulator of the current channel, which then steps
// round-robin over CHANNELS channels. cfg_we/cfg_wdata write the channel
// mode register (bit per channel: 0 millivolts, 1 microamps).
// out_if returns results: after every ROUNDS full rounds, one average per
// channel (channel 0 first), and after every input the command bytes for
// the next conversion, marked by is_last.
// Flow: an input with no block end is accumulated in ST_ACC, and ST_CMD then
// loads its command into the output register; the block returns to ST_IDLE
// and can take the next transfer. An input that ends a block adds, per
// channel, sum read, reciprocal multiply, quotient fix, scale multiply and
// scale fix. One item is in work at a time.
// A result waits in the output register while out_if.ready is low; the
// block takes the next input with a command still waiting, and stalls only
// where it must hand over a new result.
// Synchronous reset clears the mode register, accumulators, channel and
// round counters, and drops out_if.valid.
`default_nettype none

module adc_scan_block_averager_unit #(
  parameter int CHANNELS = adc_sba_pkg::CHANNELS_DEF,
  parameter int ROUNDS   = adc_sba_pkg::ROUNDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  adc_sba_in_if.sink                      in_if,
  adc_sba_out_if.source                   out_if,
  input  logic                            cfg_we,
  input  logic [adc_sba_pkg::MODE_W-1:0]  cfg_wdata
);

  adc_sba_pkg::ctrl_cmd_t  cmd;
  adc_sba_pkg::dp_status_t status;
  logic                    in_ready;

  assign in_if.ready = in_ready;

  adc_sba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  adc_sba_dp #(
    .CHANNELS (CHANNELS),
    .ROUNDS   (ROUNDS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .rx_byte_mid (in_if.rx_byte_mid),
    .rx_byte_low (in_if.rx_byte_low),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .status      (status),
    .out_if      (out_if)
  );

endmodule

`default_nettype wire

[hw/rtl/adc_sba_checker.sv]
`default_nettype none
`include "adc_scan_block_averager_unit_defines.svh"

module adc_sba_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_kind,
  input logic [adc_sba_pkg::CHAN_W-1:0]  out_channel,
  input logic [adc_sba_pkg::BYTE_W-1:0]  out_tx_first,
  input logic [adc_sba_pkg::BYTE_W-1:0]  out_tx_second,
  input logic                            out_is_last
);

  // A pending result stays offered until it is transferred.
  `ADC_SBA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  `ADC_SBA_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid, "result offered after reset")

  // Only one item is in work, so a transfer is never followed at once by another.
  `ADC_SBA_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "input taken while busy")

  // Only the command closes an item, and its bytes encode its channel.
  `ADC_SBA_ASSERT(a_cmd_bytes, out_valid && out_kind == adc_sba_pkg::KIND_CMD |-> out_is_last && out_tx_first[7:1] == adc_sba_pkg::CMD_BASE[7:1] && out_tx_first[0] == out_channel[2] && out_tx_second[7:6] == out_channel[1:0] && out_tx_second[5:0] == 6'd0, "bad command result")

  `ADC_SBA_ASSERT(a_avg_fields, out_valid && out_kind == adc_sba_pkg::KIND_AVG |-> !out_is_last && out_tx_first == 8'd0 && out_tx_second == 8'd0, "bad average result")

endmodule

bind adc_scan_block_averager_unit adc_sba_checker u_adc_sba_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_kind      (out_if.kind),
  .out_channel   (out_if.channel),
  .out_tx_first  (out_if.tx_byte_first),
  .out_tx_second (out_if.tx_byte_second),
  .out_is_last   (out_if.is_last)
);

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adc_sba_pkg::*;

  localparam int NCH         = CHANNELS_DEF;
  localparam int NROUNDS     = ROUNDS_DEF;
  // Covers the worst-case block end; leave a margin on top.
  localparam int SETTLE_CYC  = 3 + 5 * NCH + 20;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int BLOCK_ITEMS = NCH * NROUNDS;

  typedef struct packed {
    logic                kind;
    logic [CHAN_W-1:0]   channel;
    logic [BYTE_W-1:0]   tx_first;
    logic [BYTE_W-1:0]   tx_second;
    logic [AVG_W-1:0]    average;
    logic [SCALED_W-1:0] scaled;
    logic                is_last;
  } adc_result_t;

  typedef enum int {BIAS_ANY, BIAS_FULL, BIAS_ZERO, BIAS_LOW} sample_bias_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [MODE_W-1:0]   cfg_wdata;

  adc_sba_in_if  in_if ();
  adc_sba_out_if out_if ();

  adc_scan_block_averager_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state.
  logic [CHAN_W-1:0]   cur_chan;
  logic [ROUND_W-1:0]  rounds_done;
  logic [SUM_W-1:0]    chan_sums [NCH];
  logic [MODE_W-1:0]   chan_modes;
  sample_bias_t        chan_bias [NCH];

  adc_result_t         pending_results [$];

  int                  src_idle_pct;
  int                  sink_idle_pct;
  logic                hold_req;
  int                  hold_left;
  int                  mismatches;
  int                  cycle_count;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Updates the channel accumulators for one accepted sample and queues the
  // averages of a completed block followed by the next conversion command.
  task automatic accumulate_sample(input logic [BYTE_W-1:0] mid,
                                   input logic [BYTE_W-1:0] low);
    logic [SAMPLE_W-1:0] sample;
    logic [SUM_W-1:0]    quot;
    logic [AVG_W-1:0]    avg;
    longint unsigned     num;
    adc_result_t         r;
    sample = {mid[3:0] & SAMPLE_HI_MASK[3:0], low};
    chan_sums[cur_chan] = chan_sums[cur_chan] + SUM_W'(sample);
    if (cur_chan == CHAN_W'(NCH - 1)) begin
      cur_chan = '0;
      rounds_done = rounds_done + 1'b1;
      if (rounds_done == ROUND_W'(NROUNDS)) begin
        rounds_done = '0;
        for (int i = 0; i < NCH; i++) begin
          quot = chan_sums[i] / SUM_W'(NROUNDS);
          avg = (quot > SUM_W'(FULL_SCALE)) ? AVG_W'(FULL_SCALE) : quot[AVG_W-1:0];
          if (chan_modes[i])
            num = (longint'(avg) * UA_FULL) / (longint'(FULL_SCALE) * SENSE_OHMS);
          else
            num = (longint'(avg) * MV_FULL) / FULL_SCALE;
          chan_sums[i] = '0;
          r = '0;
          r.kind    = KIND_AVG;
          r.channel = CHAN_W'(i);
          r.average = avg;
          r.scaled  = num[SCALED_W-1:0];
          pending_results.push_back(r);
        end
      end
    end else begin
      cur_chan = cur_chan + 1'b1;
    end
    r = '0;
    r.kind      = KIND_CMD;
    r.channel   = cur_chan;
    r.tx_first  = CMD_BASE | {7'b0, cur_chan[2]};
    r.tx_second = {cur_chan[1:0], 6'b0};
    r.is_last   = 1'b1;
    pending_results.push_back(r);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(input logic [BYTE_W-1:0] mid, input logic [BYTE_W-1:0] low);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid       <= 1'b0;
      in_if.rx_byte_mid <= BYTE_W'($urandom);
      in_if.rx_byte_low <= BYTE_W'($urandom);
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.rx_byte_mid <= mid;
    in_if.rx_byte_low <= low;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    accumulate_sample(mid, low);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_channel_modes(input logic [MODE_W-1:0] modes);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= modes;
    @(negedge clk);
    cfg_we     <= 1'b0;
    chan_modes  = modes;
  endtask

  // Samples follow a per-channel bias chosen at the start of every block, so
  // that full-scale and zero averages show up in each mode setting.
  task automatic send_random_samples(input int count);
    logic [BYTE_W-1:0] mid;
    logic [BYTE_W-1:0] low;
    for (int n = 0; n < count; n++) begin
      if (cur_chan == '0 && rounds_done == '0) begin
        chan_bias[0] = BIAS_FULL;
        chan_bias[1] = BIAS_ZERO;
        for (int c = 2; c < NCH; c++) chan_bias[c] = sample_bias_t'($urandom_range(3));
      end
      mid = BYTE_W'($urandom);
      low = BYTE_W'($urandom);
      case (chan_bias[cur_chan])
        BIAS_FULL: begin
          mid[3:0] = 4'hF;
          low      = 8'hFF;
        end
        BIAS_ZERO: begin
          mid[3:0] = 4'h0;
          low      = 8'h00;
        end
        BIAS_LOW: mid[3:0] = 4'h0;
        default: ;
      endcase
      send_sample(mid, low);
    end
  endtask

  // Field extremes, ignored high nibble, and two full rounds of channels.
  task automatic test_directed_extremes();
    logic [BYTE_W-1:0] mids [16] = '{8'h00, 8'h0F, 8'hF0, 8'hFF, 8'h0A, 8'h05, 8'h80, 8'h01,
                                     8'h7F, 8'hF8, 8'h0C, 8'h33, 8'h00, 8'hFF, 8'h40, 8'h0F};
    logic [BYTE_W-1:0] lows [16] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80,
                                     8'hFE, 8'h7F, 8'h3C, 8'hC3, 8'hFF, 8'h00, 8'h02, 8'hFF};
    src_idle_pct  = 30;
    sink_idle_pct = 47;
    for (int i = 0; i < 16; i++) send_sample(mids[i], lows[i]);
  endtask

  // Completes the first block in voltage mode on every channel.
  task automatic test_voltage_blocks();
    src_idle_pct  = 30;
    sink_idle_pct = 47;
    send_random_samples(BLOCK_ITEMS - 16);
  endtask

  task automatic test_current_blocks();
    write_channel_modes(8'hFF);
    src_idle_pct  = 47;
    sink_idle_pct = 30;
    send_random_samples(BLOCK_ITEMS);
  endtask

  // Mixed modes with no idling; the receiver stalls long enough for the
  // block to back up and hold off its input.
  task automatic test_mixed_backpressure();
    write_channel_modes(MODE_W'($urandom_range(254, 1)));
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    send_random_samples(BLOCK_ITEMS);
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    adc_result_t got;
    adc_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.kind      = out_if.kind;
      got.channel   = out_if.channel;
      got.tx_first  = out_if.tx_byte_first;
      got.tx_second = out_if.tx_byte_second;
      got.average   = out_if.average;
      got.scaled    = out_if.scaled_value;
      got.is_last   = out_if.is_last;
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: kind=%0d ch=%0d tx=%02h %02h avg=%0d scaled=%0d last=%0d",
                   got.kind, got.channel, got.tx_first, got.tx_second, got.average,
                   got.scaled, got.is_last);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("mismatch: exp kind=%0d ch=%0d tx=%02h %02h avg=%0d scaled=%0d last=%0d",
                     want.kind, want.channel, want.tx_first, want.tx_second, want.average,
                     want.scaled, want.is_last);
            $display("          got kind=%0d ch=%0d tx=%02h %02h avg=%0d scaled=%0d last=%0d",
                     got.kind, got.channel, got.tx_first, got.tx_second, got.average,
                     got.scaled, got.is_last);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("adc_scan_block_averager_unit verification failed");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.rx_byte_mid = '0;
    in_if.rx_byte_low = '0;
    out_if.ready      = 1'b0;
    hold_req          = 1'b0;
    hold_left         = 0;
    mismatches        = 0;
    cycle_count       = 0;
    src_idle_pct      = 0;
    sink_idle_pct     = 0;
    cur_chan          = '0;
    rounds_done       = '0;
    chan_modes        = '0;
    for (int c = 0; c < NCH; c++) begin
      chan_sums[c] = '0;
      chan_bias[c] = BIAS_ANY;
    end
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_channel_modes(8'h00);
    test_directed_extremes();
    test_voltage_blocks();
    test_current_blocks();
    test_mixed_backpressure();

    wait_for_drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("adc_scan_block_averager_unit verification clean");
    end else begin
      $display("adc_scan_block_averager_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
